// ===== rtl/nec_ir_pulse_decoder_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef NEC_IR_PULSE_DECODER_DEFINES_SVH
`define NEC_IR_PULSE_DECODER_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define NIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define NIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nir_pkg.sv =====
package nir_pkg;

    localparam int unsigned DUR_W   = 16;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned SHIFT_W = 32;
    localparam int unsigned WORD_W  = 16;

    localparam logic [COUNT_W-1:0] FRAME_ENTRIES = 7'd66;

    localparam logic [DUR_W-1:0] LEAD_MARK_MIN  = 16'd8000;
    localparam logic [DUR_W-1:0] LEAD_MARK_MAX  = 16'd10500;
    localparam logic [DUR_W-1:0] LEAD_SPACE_MIN = 16'd4000;
    localparam logic [DUR_W-1:0] LEAD_SPACE_MAX = 16'd5000;
    localparam logic [DUR_W-1:0] BIT_MARK_MIN   = 16'd400;
    localparam logic [DUR_W-1:0] BIT_MARK_MAX   = 16'd800;
    localparam logic [DUR_W-1:0] ONE_SPACE_LO   = 16'd1300;
    localparam logic [DUR_W-1:0] ONE_SPACE_HI   = 16'd2000;
    localparam logic [DUR_W-1:0] ZERO_SPACE_LO  = 16'd350;
    localparam logic [DUR_W-1:0] ZERO_SPACE_HI  = 16'd800;

    typedef struct packed {
        logic [DUR_W-1:0] duration_us;
        logic             last_entry;
    } t_in_beat;

    typedef struct packed {
        logic              decode_ok;
        logic [WORD_W-1:0] address_word;
        logic [WORD_W-1:0] command_word;
    } t_out_beat;

    typedef struct packed {
        logic lead_mark_ok;
        logic lead_space_ok;
        logic bit_mark_ok;
        logic space_one;
        logic space_zero;
    } t_timing;

endpackage

// ===== rtl/nir_classify.sv =====
module nir_classify (
    input  logic [nir_pkg::DUR_W-1:0] i_duration_us,
    output nir_pkg::t_timing          o_timing
);

    always_comb begin
        o_timing.lead_mark_ok  = (i_duration_us >= nir_pkg::LEAD_MARK_MIN)
                              && (i_duration_us <= nir_pkg::LEAD_MARK_MAX);
        o_timing.lead_space_ok = (i_duration_us >= nir_pkg::LEAD_SPACE_MIN)
                              && (i_duration_us <= nir_pkg::LEAD_SPACE_MAX);
        o_timing.bit_mark_ok   = (i_duration_us >= nir_pkg::BIT_MARK_MIN)
                              && (i_duration_us <= nir_pkg::BIT_MARK_MAX);
        o_timing.space_one     = (i_duration_us > nir_pkg::ONE_SPACE_LO)
                              && (i_duration_us < nir_pkg::ONE_SPACE_HI);
        o_timing.space_zero    = (i_duration_us > nir_pkg::ZERO_SPACE_LO)
                              && (i_duration_us < nir_pkg::ZERO_SPACE_HI);
    end

endmodule

// ===== rtl/nec_ir_pulse_decoder.sv =====
// Decodes one NEC infrared frame from a stream of pulse durations in microseconds,
// alternating mark and space, one beat per duration, with the last beat of a capture
// flagged. The decoder accepts one beat every clock cycle unless the input is held up.
// Each beat is registered on entry, then checked and shifted from that register; the
// result enters the output register when the flagged last beat advances. Only a last
// beat held by a stalled output register holds up the input; ordinary beats never do.
// Every capture yields exactly one result beat, on its last entry.
`include "nec_ir_pulse_decoder_defines.svh"

module nec_ir_pulse_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  nir_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output nir_pkg::t_out_beat o_out_data
);

    logic                          r_in_valid;
    nir_pkg::t_in_beat             r_in;
    logic [nir_pkg::COUNT_W-1:0]   r_count;
    logic [nir_pkg::COUNT_W-1:0]   n_count;
    logic [nir_pkg::SHIFT_W-1:0]   r_shift;
    logic [nir_pkg::SHIFT_W-1:0]   n_shift;
    logic                          r_failed;
    logic                          n_failed;
    logic                          r_out_valid;
    nir_pkg::t_out_beat            r_out;
    nir_pkg::t_out_beat            n_out;
    nir_pkg::t_timing              timing;
    logic                          advance;
    logic                          in_take;
    logic                          in_frame;
    logic                          bad_now;
    logic                          bit_val;
    logic                          frame_ok;

    nir_classify u_classify (
        .i_duration_us (r_in.duration_us),
        .o_timing      (timing)
    );

    assign advance    = r_in_valid && !(r_in.last_entry && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        in_frame = r_count < nir_pkg::FRAME_ENTRIES;
        bit_val  = timing.space_one;
        bad_now  = 1'b0;
        n_shift  = r_shift;
        n_count  = r_count;
        if (r_count == '0) begin
            bad_now = !timing.lead_mark_ok;
        end else if (r_count == nir_pkg::COUNT_W'(1)) begin
            bad_now = !timing.lead_space_ok;
        end else if (in_frame) begin
            if (!r_count[0]) begin
                bad_now = !timing.bit_mark_ok;
            end else begin
                bad_now = !timing.space_one && !timing.space_zero;
                n_shift = {r_shift[nir_pkg::SHIFT_W-2:0], bit_val};
            end
        end
        if (in_frame) begin
            n_count = r_count + nir_pkg::COUNT_W'(1);
        end
        n_failed = r_failed || bad_now;
        frame_ok = (n_count >= nir_pkg::FRAME_ENTRIES) && !n_failed;
        n_out.decode_ok    = frame_ok;
        n_out.address_word = frame_ok ? n_shift[nir_pkg::SHIFT_W-1:nir_pkg::WORD_W]
                                      : '0;
        n_out.command_word = frame_ok ? n_shift[nir_pkg::WORD_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_shift  <= '0;
            r_failed <= 1'b0;
        end else if (advance) begin
            if (r_in.last_entry) begin
                r_count  <= '0;
                r_shift  <= '0;
                r_failed <= 1'b0;
            end else begin
                r_count  <= n_count;
                r_shift  <= n_shift;
                r_failed <= n_failed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last_entry) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in.last_entry) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A failed frame reports zero words.
    `NIR_ASSERT_NOW(a_fail_zero, r_out_valid && !r_out.decode_ok,
        r_out.address_word == '0 && r_out.command_word == '0,
        "failed frame carries nonzero words")
    // The entry count saturates at the frame length.
    `NIR_ASSERT_NOW(a_count_sat, 1'b1, r_count <= nir_pkg::FRAME_ENTRIES,
        "entry count beyond frame length")
    // The last beat of a capture clears the frame state.
    `NIR_ASSERT_NEXT(a_last_clears, advance && r_in.last_entry,
        r_count == '0 && r_shift == '0 && !r_failed,
        "frame state not cleared after last beat")
    // The last beat of a capture always produces a result beat.
    `NIR_ASSERT_NEXT(a_last_result, advance && r_in.last_entry, r_out_valid,
        "no result after last beat")

endmodule

// ===== dv/nec_ir_pulse_decoder_tb.sv =====
`timescale 1ns / 100ps

module nec_ir_pulse_decoder_tb;

    localparam int ITEM_TARGET   = 1200;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int DIRECTED_ROWS = 21;

    localparam nir_pkg::t_out_beat REJECTED = '0;

    typedef struct packed {
        logic [nir_pkg::DUR_W-1:0] duration;
        logic                      last;
        logic                      typed;
        nir_pkg::t_out_beat        result;
    } t_directed_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    nir_pkg::t_in_beat  i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    nir_pkg::t_out_beat o_out_data;

    logic [nir_pkg::COUNT_W-1:0] frame_len  = '0;
    logic [nir_pkg::SHIFT_W-1:0] frame_bits = '0;
    logic                        frame_bad  = 1'b0;

    nir_pkg::t_out_beat pending_frames[$];

    int in_idle_pct    = 30;
    int out_stall_pct  = 70;
    int beats_sent     = 0;
    int captures_sent  = 0;
    int frames_decoded = 0;
    int frames_refused = 0;
    int errors         = 0;
    int cycle_count    = 0;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{16'd0,     1'b1, 1'b1, REJECTED},
        '{16'd65535, 1'b1, 1'b1, REJECTED},
        '{16'd8000,  1'b0, 1'b0, REJECTED},
        '{16'd4000,  1'b1, 1'b1, REJECTED},
        '{16'd10500, 1'b0, 1'b0, REJECTED},
        '{16'd5000,  1'b0, 1'b0, REJECTED},
        '{16'd400,   1'b0, 1'b0, REJECTED},
        '{16'd1999,  1'b0, 1'b0, REJECTED},
        '{16'd800,   1'b0, 1'b0, REJECTED},
        '{16'd351,   1'b1, 1'b1, REJECTED},
        '{16'd7999,  1'b0, 1'b0, REJECTED},
        '{16'd3999,  1'b0, 1'b0, REJECTED},
        '{16'd399,   1'b0, 1'b0, REJECTED},
        '{16'd2000,  1'b0, 1'b0, REJECTED},
        '{16'd801,   1'b0, 1'b0, REJECTED},
        '{16'd350,   1'b0, 1'b0, REJECTED},
        '{16'd800,   1'b0, 1'b0, REJECTED},
        '{16'd1300,  1'b0, 1'b0, REJECTED},
        '{16'd10501, 1'b0, 1'b0, REJECTED},
        '{16'd800,   1'b1, 1'b1, REJECTED},
        '{16'd5001,  1'b1, 1'b1, REJECTED}
    };

    nec_ir_pulse_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic decode_entry(input nir_pkg::t_in_beat b, output logic done,
                                output nir_pkg::t_out_beat res);
        logic [nir_pkg::DUR_W-1:0] d;
        logic                      bit_val;
        d       = b.duration_us;
        bit_val = 1'b0;
        if (frame_len == 0) begin
            if (d < nir_pkg::LEAD_MARK_MIN || d > nir_pkg::LEAD_MARK_MAX) frame_bad = 1'b1;
        end else if (frame_len == 1) begin
            if (d < nir_pkg::LEAD_SPACE_MIN || d > nir_pkg::LEAD_SPACE_MAX) frame_bad = 1'b1;
        end else if (frame_len < nir_pkg::FRAME_ENTRIES) begin
            if (!frame_len[0]) begin
                if (d < nir_pkg::BIT_MARK_MIN || d > nir_pkg::BIT_MARK_MAX) frame_bad = 1'b1;
            end else begin
                if (d > nir_pkg::ONE_SPACE_LO && d < nir_pkg::ONE_SPACE_HI) begin
                    bit_val = 1'b1;
                end else if (!(d > nir_pkg::ZERO_SPACE_LO && d < nir_pkg::ZERO_SPACE_HI)) begin
                    frame_bad = 1'b1;
                end
                frame_bits = {frame_bits[nir_pkg::SHIFT_W-2:0], bit_val};
            end
        end
        if (frame_len < nir_pkg::FRAME_ENTRIES) frame_len = frame_len + nir_pkg::COUNT_W'(1);
        done = b.last_entry;
        res  = '0;
        if (b.last_entry) begin
            if (frame_len >= nir_pkg::FRAME_ENTRIES && !frame_bad) begin
                res.decode_ok    = 1'b1;
                res.address_word = frame_bits[31:16];
                res.command_word = frame_bits[15:0];
            end
            frame_len  = '0;
            frame_bits = '0;
            frame_bad  = 1'b0;
        end
    endtask

    task automatic send_beat(input nir_pkg::t_in_beat b, input logic typed,
                             input nir_pkg::t_out_beat typed_res);
        logic               done;
        nir_pkg::t_out_beat res;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
        decode_entry(b, done, res);
        if (done) begin
            captures_sent++;
            pending_frames.push_back(typed ? typed_res : res);
        end
        if (beats_sent == ITEM_TARGET / 3) begin
            in_idle_pct   = 70;
            out_stall_pct = 30;
        end else if (beats_sent == 2 * ITEM_TARGET / 3) begin
            in_idle_pct   = 0;
            out_stall_pct = 0;
        end
    endtask

    function automatic logic [nir_pkg::DUR_W-1:0] pick_in(input int lo, input int hi);
        case ($urandom_range(3))
            0: return nir_pkg::DUR_W'(lo);
            1: return nir_pkg::DUR_W'(hi);
            default: return nir_pkg::DUR_W'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic logic [nir_pkg::DUR_W-1:0] pick_out(input int lo, input int hi);
        case ($urandom_range(3))
            0: return nir_pkg::DUR_W'(lo - 1);
            1: return nir_pkg::DUR_W'(hi + 1);
            2: return nir_pkg::DUR_W'($urandom_range(lo - 1, 0));
            default: return nir_pkg::DUR_W'($urandom_range(65535, hi + 1));
        endcase
    endfunction

    function automatic logic [nir_pkg::DUR_W-1:0] bad_space();
        case ($urandom_range(4))
            0: return nir_pkg::ZERO_SPACE_LO;
            1: return nir_pkg::ZERO_SPACE_HI;
            2: return nir_pkg::ONE_SPACE_LO;
            3: return nir_pkg::ONE_SPACE_HI;
            default: return nir_pkg::DUR_W'($urandom_range(65535, 0));
        endcase
    endfunction

    function automatic logic [nir_pkg::DUR_W-1:0] good_entry(input int idx);
        if (idx == 0) return pick_in(nir_pkg::LEAD_MARK_MIN, nir_pkg::LEAD_MARK_MAX);
        if (idx == 1) return pick_in(nir_pkg::LEAD_SPACE_MIN, nir_pkg::LEAD_SPACE_MAX);
        if (idx % 2 == 0) return pick_in(nir_pkg::BIT_MARK_MIN, nir_pkg::BIT_MARK_MAX);
        if ($urandom_range(1)) begin
            return pick_in(nir_pkg::ONE_SPACE_LO + 1, nir_pkg::ONE_SPACE_HI - 1);
        end
        return pick_in(nir_pkg::ZERO_SPACE_LO + 1, nir_pkg::ZERO_SPACE_HI - 1);
    endfunction

    function automatic logic [nir_pkg::DUR_W-1:0] broken_entry(input int idx);
        if (idx == 0) return pick_out(nir_pkg::LEAD_MARK_MIN, nir_pkg::LEAD_MARK_MAX);
        if (idx == 1) return pick_out(nir_pkg::LEAD_SPACE_MIN, nir_pkg::LEAD_SPACE_MAX);
        if (idx % 2 == 0) return pick_out(nir_pkg::BIT_MARK_MIN, nir_pkg::BIT_MARK_MAX);
        return bad_space();
    endfunction

    task automatic send_capture();
        logic [nir_pkg::DUR_W-1:0] durs[$];
        nir_pkg::t_in_beat         b;
        int                        len;
        int                        kind;
        int                        bad_idx;
        kind = $urandom_range(9);
        if (kind < 6) begin
            for (int i = 0; i < nir_pkg::FRAME_ENTRIES; i++) durs.push_back(good_entry(i));
            if ($urandom_range(3) == 0) begin
                bad_idx = $urandom_range(nir_pkg::FRAME_ENTRIES - 1);
                durs[bad_idx] = broken_entry(bad_idx);
            end
            case ($urandom_range(9))
                0, 1: begin
                    len = $urandom_range(14, 1);
                    repeat (len) durs.push_back(nir_pkg::DUR_W'($urandom_range(65535, 0)));
                end
                2: durs = durs[0:$urandom_range(nir_pkg::FRAME_ENTRIES - 2, 1)];
                default: ;
            endcase
        end else begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(1)) begin
                    durs.push_back(good_entry(i));
                end else begin
                    durs.push_back(nir_pkg::DUR_W'($urandom_range(65535, 0)));
                end
            end
        end
        foreach (durs[i]) begin
            b.duration_us = durs[i];
            b.last_entry  = (i == durs.size() - 1);
            send_beat(b, 1'b0, REJECTED);
        end
    endtask

    function automatic void check_field(input string name,
                                        input logic [nir_pkg::WORD_W-1:0] want,
                                        input logic [nir_pkg::WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic check_frame(input nir_pkg::t_out_beat got);
        nir_pkg::t_out_beat want;
        if (pending_frames.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got ok=%b addr=%h cmd=%h",
                     $time, got.decode_ok, got.address_word, got.command_word);
            errors++;
        end else begin
            want = pending_frames.pop_front();
            check_field("decode_ok", nir_pkg::WORD_W'(want.decode_ok),
                        nir_pkg::WORD_W'(got.decode_ok));
            check_field("address_word", want.address_word, got.address_word);
            check_field("command_word", want.command_word, got.command_word);
            if (want.decode_ok) frames_decoded++;
            else frames_refused++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_frame(o_out_data);
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        nir_pkg::t_in_beat b;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i]) begin
            b.duration_us = directed_rows[i].duration;
            b.last_entry  = directed_rows[i].last;
            send_beat(b, directed_rows[i].typed, directed_rows[i].result);
        end
        while (beats_sent < ITEM_TARGET) send_capture();
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Drove %0d duration beats in %0d captures under three idle and stall mixes.",
                 beats_sent, captures_sent);
        $display("Checked %0d decoded frames and %0d rejected captures.",
                 frames_decoded, frames_refused);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
